### rtl/ird_pkg.sv
// Shared types and constants for the integer to radix digits converter.
package ird_pkg;

	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [3:0] RADIX_MIN  = 4'd2;
	localparam logic [3:0] RADIX_MAX  = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_LOAD,
		ST_OUT
	} state_t;

	// Control from the sequencer to the shared divider.
	typedef struct packed {
		logic       start;
		logic [3:0] divisor;
	} div_ctrl_t;

	// Status from the shared divider back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/ird_ifs.sv
// Valid/ready channel interfaces for the number input and the digit output.
interface ird_num_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [3:0]            radix;

	modport source (output valid, value, radix, input ready);
	modport sink   (input valid, value, radix, output ready);
endinterface

interface ird_dig_if;
	logic       valid;
	logic       ready;
	logic [5:0] digit_char;
	logic       last;
	logic       bad_radix;

	modport source (output valid, digit_char, last, bad_radix, input ready);
	modport sink   (input valid, digit_char, last, bad_radix, output ready);
endinterface

### rtl/ird_div.sv
// Restoring divider by a 4-bit radix, one quotient bit per cycle.
module ird_div #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ird_pkg::div_ctrl_t    ctrl,
	input  logic [VALUE_BITS-1:0] dividend,
	output ird_pkg::div_stat_t    stat,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [3:0]            remainder
);
	localparam int CNT_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] work_q;
	logic [3:0]            rem_q;
	logic [3:0]            divisor_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [4:0]            trial;
	logic                  fits;
	logic [4:0]            diff;

	// The partial remainder stays below the divisor, so the trial is five bits.
	assign trial = {rem_q, work_q[VALUE_BITS-1]};
	assign fits  = (trial >= {1'b0, divisor_q});
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits shift out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= ctrl.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[VALUE_BITS-2:0], fits};
			rem_q  <= fits ? diff[3:0] : trial[3:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= CNT_W'(VALUE_BITS - 1))
		else $error("divider step count out of range");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !ctrl.start |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

### rtl/ird_stack.sv
// Digit store: one write port, one read port with registered read data.
module ird_stack #(
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [3:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [3:0]               rd_data
);
	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/integer_to_radix_digits_top.sv
// Each digit of a number takes one pass through the shared divider; each digit word then
// passes through store read, output load and handoff, which waits for the sink to be ready.
// A base outside 2..10 gives its single error word in the cycle after the number is taken.
// Throughput: one number at a time; the divider's bit-serial loop sets the pace.
// Reset (arst_n, asynchronous, active low) returns the sequencer to idle with no word held.
module integer_to_radix_digits_top #(
	parameter int VALUE_BITS = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	ird_num_if.sink        num,
	ird_dig_if.source      digits
);
	// The digit count must reach VALUE_BITS itself; the store index only needs to reach
	// VALUE_BITS-1.
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int PTR_W = $clog2(VALUE_BITS);

	ird_pkg::state_t       state_q;
	ird_pkg::state_t       state_d;
	ird_pkg::div_ctrl_t    div_ctrl;
	ird_pkg::div_stat_t    div_stat;
	logic [VALUE_BITS-1:0] dividend;
	logic [VALUE_BITS-1:0] quotient;
	logic [3:0]            remainder;
	logic [3:0]            radix_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [5:0]            char_q;
	logic                  last_q;
	logic                  bad_q;
	logic                  radix_ok;
	logic                  quo_zero;
	logic                  push;
	logic                  rd_en;
	logic [3:0]            rd_data;

	assign radix_ok = (num.radix >= ird_pkg::RADIX_MIN) && (num.radix <= ird_pkg::RADIX_MAX);
	assign quo_zero = (quotient == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ird_pkg::ST_IDLE: begin
				if (num.valid) begin
					state_d = radix_ok ? ird_pkg::ST_DIV : ird_pkg::ST_OUT;
				end
			end
			ird_pkg::ST_DIV: begin
				if (div_stat.done && quo_zero) begin
					state_d = ird_pkg::ST_RD;
				end
			end
			ird_pkg::ST_RD: begin
				state_d = ird_pkg::ST_LOAD;
			end
			ird_pkg::ST_LOAD: begin
				state_d = ird_pkg::ST_OUT;
			end
			ird_pkg::ST_OUT: begin
				if (digits.ready) begin
					state_d = last_q ? ird_pkg::ST_IDLE : ird_pkg::ST_RD;
				end
			end
			default: begin
				state_d = ird_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. Each division feeds its quotient back as the next dividend,
	// and every remainder is pushed as the next more significant digit, least
	// significant first, so the store is later read from the top down.
	always_comb begin
		num.ready      = 1'b0;
		digits.valid   = 1'b0;
		div_ctrl.start = 1'b0;
		div_ctrl.divisor = radix_q;
		dividend       = quotient;
		push           = 1'b0;
		rd_en          = 1'b0;
		case (state_q)
			ird_pkg::ST_IDLE: begin
				num.ready        = 1'b1;
				div_ctrl.start   = num.valid && radix_ok;
				div_ctrl.divisor = num.radix;
				dividend         = num.value;
			end
			ird_pkg::ST_DIV: begin
				push           = div_stat.done;
				div_ctrl.start = div_stat.done && !quo_zero;
			end
			ird_pkg::ST_RD: begin
				rd_en = 1'b1;
			end
			ird_pkg::ST_OUT: begin
				digits.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ird_pkg::ST_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ird_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end else if (push) begin
				cnt_q <= cnt_q + 1'b1;
				if (quo_zero) begin
					// The digit just written is the most significant one.
					ptr_q <= cnt_q[PTR_W-1:0];
				end
			end
			if (state_q == ird_pkg::ST_OUT && digits.ready && !last_q) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// Output word register; an error word is loaded straight from idle.
	always_ff @(posedge clk) begin
		if (state_q == ird_pkg::ST_IDLE && num.valid) begin
			radix_q <= num.radix;
			char_q  <= ird_pkg::ASCII_ZERO;
			last_q  <= 1'b1;
			bad_q   <= 1'b1;
		end else if (state_q == ird_pkg::ST_LOAD) begin
			char_q <= ird_pkg::ASCII_ZERO + {2'b00, rd_data};
			last_q <= (ptr_q == '0);
			bad_q  <= 1'b0;
		end
	end

	assign digits.digit_char = char_q;
	assign digits.last       = last_q;
	assign digits.bad_radix  = bad_q;

	ird_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (dividend),
		.stat      (div_stat),
		.quotient  (quotient),
		.remainder (remainder)
	);

	ird_stack #(
		.DEPTH(VALUE_BITS)
	) u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (cnt_q[PTR_W-1:0]),
		.wr_data (remainder),
		.rd_en   (rd_en),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	// An error word is always the only word of its number.
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		digits.valid && digits.bad_radix |-> digits.last)
		else $error("error word without last mark");

	// The block never takes a new number while a word is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		num.ready |-> !digits.valid)
		else $error("input ready while a word is pending");

	// No number has more digits than the value has bits.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(VALUE_BITS))
		else $error("digit count overflow");

	// Divider results arrive only while the sequencer waits for them.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ird_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

endmodule

### test/ird_digit_checker.sv
// Checker that predicts the digit words of each accepted number and compares them on the output.
`timescale 1ns / 100ps
module ird_digit_checker #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  num_valid,
	input  logic                  num_ready,
	input  logic [VALUE_BITS-1:0] num_value,
	input  logic [3:0]            num_radix,
	input  logic                  dig_valid,
	input  logic                  dig_ready,
	input  logic [5:0]            dig_char,
	input  logic                  dig_last,
	input  logic                  dig_bad_radix,
	output int unsigned           failures,
	output int unsigned           words_pending
);

	typedef struct packed {
		logic [5:0] digit_char;
		logic       last;
		logic       bad_radix;
	} digit_word_t;

	digit_word_t digit_words_due [$];
	int unsigned fail_tally = 0;

	// Expand one number into its digit words, most significant first.
	task automatic queue_digits_of(input logic [VALUE_BITS-1:0] value, input logic [3:0] radix);
		logic [VALUE_BITS-1:0] rest;
		logic [5:0]            msd_first [$];
		digit_word_t           w;
		if (radix < ird_pkg::RADIX_MIN || radix > ird_pkg::RADIX_MAX) begin
			w.digit_char = ird_pkg::ASCII_ZERO;
			w.last       = 1'b1;
			w.bad_radix  = 1'b1;
			digit_words_due.push_back(w);
		end else begin
			rest = value;
			do begin
				msd_first.push_front(ird_pkg::ASCII_ZERO + 6'(rest % VALUE_BITS'(radix)));
				rest = rest / VALUE_BITS'(radix);
			end while (rest != '0);
			for (int k = 0; k < msd_first.size(); k++) begin
				w.digit_char = msd_first[k];
				w.last       = (k == msd_first.size() - 1);
				w.bad_radix  = 1'b0;
				digit_words_due.push_back(w);
			end
		end
	endtask

	always @(posedge clk) begin
		digit_word_t want;
		if (arst_n) begin
			if (num_valid && num_ready)
				queue_digits_of(num_value, num_radix);
			if (dig_valid && dig_ready) begin
				if (digit_words_due.size() == 0) begin
					$error("digit word with nothing expected: digit_char %0d last %0b bad_radix %0b",
						dig_char, dig_last, dig_bad_radix);
					fail_tally++;
				end else begin
					want = digit_words_due.pop_front();
					if (dig_char !== want.digit_char) begin
						$error("digit_char: expected %0d, got %0d", want.digit_char, dig_char);
						fail_tally++;
					end
					if (dig_last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, dig_last);
						fail_tally++;
					end
					if (dig_bad_radix !== want.bad_radix) begin
						$error("bad_radix: expected %0b, got %0b", want.bad_radix, dig_bad_radix);
						fail_tally++;
					end
				end
			end
		end
		failures      <= fail_tally;
		words_pending <= digit_words_due.size();
	end

endmodule

### test/tb_integer_to_radix_digits_top.sv
// Testbench top for the integer to radix digits converter: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_integer_to_radix_digits_top;

	localparam int VALUE_BITS      = 31;
	// Number of random numbers after the directed part.
	localparam int RANDOM_NUMBERS  = 195;
	// The last numbers run with no idling on either side.
	localparam int CALM_TAIL       = 40;
	// Early on the digit sink refuses words this long, so the block backs up.
	localparam int HOLD_OFF_CYCLES = 400;
	// Cycles to watch after the last expected word has arrived.
	localparam int DRAIN_CYCLES    = 64;

	logic clk = 1'b0;
	logic arst_n;
	// Set near the end of the run; both sides stop idling from then on.
	logic calm;

	int unsigned failures;
	int unsigned words_pending;

	ird_num_if #(.VALUE_BITS(VALUE_BITS)) num_ch ();
	ird_dig_if                            dig_ch ();

	integer_to_radix_digits_top #(.VALUE_BITS(VALUE_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch.sink),
		.digits (dig_ch.source)
	);

	// The checker sees both channels, builds the expected digit words from
	// every accepted number and compares each accepted digit word in order.
	ird_digit_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_valid     (num_ch.valid),
		.num_ready     (num_ch.ready),
		.num_value     (num_ch.value),
		.num_radix     (num_ch.radix),
		.dig_valid     (dig_ch.valid),
		.dig_ready     (dig_ch.ready),
		.dig_char      (dig_ch.digit_char),
		.dig_last      (dig_ch.last),
		.dig_bad_radix (dig_ch.bad_radix),
		.failures      (failures),
		.words_pending (words_pending)
	);

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the block hangs. The slowest legal run is well under
	// two milliseconds: base 2 numbers of full width, every digit word held
	// back by the longest sink stall and every number by the longest gap.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one number and hold it until the block takes it. The word is
	// taken at the edge where valid and ready are both high; the caller may
	// drive the next word at that same edge.
	task automatic offer_number(input logic [VALUE_BITS-1:0] value, input logic [3:0] radix);
		num_ch.valid <= 1'b1;
		num_ch.value <= value;
		num_ch.radix <= radix;
		do @(posedge clk); while (!num_ch.ready);
	endtask

	// Drop valid for a burst of idle cycles.
	task automatic idle_sender(input int unsigned cycles);
		num_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Digit sink: a long refusal right after reset, then random bursts of
	// stall mixed with stretches of steady acceptance, then always ready.
	initial begin
		int unsigned stretch;
		logic        level;
		dig_ch.ready = 1'b0;
		@(posedge clk iff arst_n);
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		forever begin
			if (calm) begin
				dig_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				level   = ($urandom_range(0, 2) != 0);
				stretch = level ? $urandom_range(1, 30) : $urandom_range(1, 17);
				dig_ch.ready <= level;
				repeat (stretch) @(posedge clk);
			end
		end
	end

	// Number source.
	initial begin
		logic [VALUE_BITS-1:0] value;
		logic [3:0]            radix;
		logic [31:0]           raw;
		int unsigned           width;
		int unsigned           pick;

		num_ch.valid = 1'b0;
		num_ch.value = '0;
		num_ch.radix = '0;
		calm         = 1'b0;
		arst_n       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed numbers. The sink is refusing words while these go in,
		// so the block fills up and must hold off its number input.
		// Zero must give the single character '0' in any base.
		offer_number('0, 4'd2);
		offer_number('0, 4'd10);
		offer_number('0, 4'd7);
		// Full-width value: the longest digit run in base 2, and others.
		offer_number({VALUE_BITS{1'b1}}, 4'd2);
		offer_number({VALUE_BITS{1'b1}}, 4'd3);
		offer_number({VALUE_BITS{1'b1}}, 4'd9);
		offer_number({VALUE_BITS{1'b1}}, 4'd10);
		// Single-digit values and the step to two digits.
		offer_number(VALUE_BITS'(1), 4'd2);
		offer_number(VALUE_BITS'(1), 4'd5);
		offer_number(VALUE_BITS'(9), 4'd10);
		offer_number(VALUE_BITS'(10), 4'd10);
		offer_number(VALUE_BITS'(7), 4'd8);
		offer_number(VALUE_BITS'(8), 4'd8);
		// Powers of the base and one below them.
		offer_number(VALUE_BITS'(1) << (VALUE_BITS - 1), 4'd2);
		offer_number(VALUE_BITS'(387420489), 4'd9);
		offer_number(VALUE_BITS'(387420488), 4'd9);
		offer_number(VALUE_BITS'(1000000000), 4'd10);
		offer_number(VALUE_BITS'(999999999), 4'd10);
		// Bases outside 2..10 give one error word whatever the value.
		offer_number({VALUE_BITS{1'b1}}, 4'd0);
		offer_number('0, 4'd1);
		offer_number(VALUE_BITS'(12345), 4'd11);
		offer_number(VALUE_BITS'(1), 4'd12);
		offer_number(VALUE_BITS'(77), 4'd13);
		offer_number(VALUE_BITS'(5), 4'd14);
		offer_number({VALUE_BITS{1'b1}}, 4'd15);

		// Random numbers. The value length is drawn first so that short and
		// long digit runs both come up often; most bases are legal.
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			if (i == RANDOM_NUMBERS - CALM_TAIL)
				calm <= 1'b1;
			if (i < RANDOM_NUMBERS - CALM_TAIL && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 17));
			raw = $urandom;
			if ($urandom_range(0, 4) != 0) begin
				width = $urandom_range(1, VALUE_BITS);
				raw   = raw >> (32 - width);
			end
			value = raw[VALUE_BITS-1:0];
			if ($urandom_range(0, 6) != 0) begin
				radix = 4'($urandom_range(ird_pkg::RADIX_MIN, ird_pkg::RADIX_MAX));
			end else begin
				pick  = $urandom_range(0, 6);
				radix = (pick < 2) ? 4'(pick) : 4'(pick + 9);
			end
			offer_number(value, radix);
		end
		num_ch.valid <= 1'b0;

		// Let every predicted word arrive, then watch a little longer for
		// any stray word. The pending count is polled only after it already
		// includes the words of the last number.
		@(posedge clk);
		while (words_pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && words_pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
